// ===== sv/bdq_pkg.sv =====
// Shared types and codes for the bounded deque engine.
package bdq_pkg;

  // Command kind codes on the input channel
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_DUMP       = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_ELEMENT    = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  // Classified command
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               at_back;
    logic               dump;
    logic signed [31:0] value;
  } cmd_t;

endpackage

// ===== sv/bounded_deque_engine.sv =====
// Top level of the bounded deque engine.
//
// Input channel (in_valid/in_ready, in_kind, in_value) carries one command per
// transaction: push front, push back, pop front, pop back or dump all. Unused
// kind codes are swallowed without effect.
// Result channel (out_valid/out_ready, out_status, out_element, out_last)
// carries error results and dumped elements, front to back, with out_last
// set on the final result of each command.
// A front end registers and classifies commands into a four-entry command
// queue; the back end executes one command at a time from that queue.
// A dump streams one element per cycle while the receiver keeps up, set by
// the single read port of the element memory. An error result passes the
// front-end holding register, the command queue, stage 1 and the output
// register; a dumped element also waits for the dump sequencer to start.
// Reset clears the pointers and the occupancy count; the storage itself is
// not cleared and needs no clearing pass. When the receiver stalls, results
// wait in the output register and a staging register, the back end halts
// on errors and dumps, and the command queue fills until in_ready drops.
module bounded_deque_engine #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_element,
  output logic                out_last
);
  import bdq_pkg::*;

  logic fe_valid;
  logic fe_ready;
  cmd_t fe_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  bdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_value  (in_value),
    .cmd_valid (fe_valid),
    .cmd_ready (fe_ready),
    .cmd       (fe_cmd)
  );

  bdq_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_cmd   (fe_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_element (out_element),
    .out_last    (out_last)
  );

endmodule

// ===== sv/bdq_front.sv =====
// Front end: accepts input transactions, classifies them, drops unused kinds.
module bdq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic signed [31:0]  in_value,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output bdq_pkg::cmd_t       cmd
);
  import bdq_pkg::*;

  logic  hold_v_r;
  logic  hold_v_nxt;
  cmd_t  hold_cmd_r;
  cmd_t  dec_cmd;
  logic  legal;

  // Decode the kind field
  always_comb begin
    dec_cmd       = '0;
    dec_cmd.value = in_value;
    legal         = 1'b1;
    case (in_kind)
      KIND_PUSH_FRONT: begin
        dec_cmd.push = 1'b1;
      end
      KIND_PUSH_BACK: begin
        dec_cmd.push    = 1'b1;
        dec_cmd.at_back = 1'b1;
      end
      KIND_POP_FRONT: begin
        dec_cmd.pop = 1'b1;
      end
      KIND_POP_BACK: begin
        dec_cmd.pop     = 1'b1;
        dec_cmd.at_back = 1'b1;
      end
      KIND_DUMP: begin
        dec_cmd.dump = 1'b1;
      end
      default: begin
        legal = 1'b0;
      end
    endcase
  end

  // Single holding register toward the command queue
  assign in_ready  = !hold_v_r || cmd_ready;
  assign cmd_valid = hold_v_r;
  assign cmd       = hold_cmd_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (in_valid && in_ready) begin
      hold_v_nxt = legal;
    end else if (cmd_ready) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && legal) begin
      hold_cmd_r <= dec_cmd;
    end
  end

endmodule

// ===== sv/bdq_cmd_fifo.sv =====
// Short command queue decoupling the front end from the back end.
module bdq_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  bdq_pkg::cmd_t  wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output bdq_pkg::cmd_t  rd_cmd
);
  import bdq_pkg::*;

  cmd_t                 slot_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_r;
  logic [CMDQ_AW-1:0]   rd_ptr_r;
  logic [CMDQ_AW:0]     count_r;
  logic [CMDQ_AW:0]     count_nxt;
  logic                 do_wr;
  logic                 do_rd;

  assign wr_ready = count_r != (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Occupancy update
  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== sv/bdq_back.sv =====
// Back end: ring buffer storage, pointers, dump sequencer and result stages.
module bdq_back #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  bdq_pkg::cmd_t       cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_element,
  output logic                out_last
);
  import bdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] mem_rd_r;

  logic [IW-1:0] front_r;
  logic [CW-1:0] occ_r;
  logic [IW-1:0] rd_ptr_r;
  logic [CW-1:0] rem_r;
  logic          dump_busy_r;

  logic          s1_v_r;
  logic [1:0]    s1_status_r;
  logic          s1_last_r;

  logic          out_v_r;
  logic [1:0]    out_status_r;
  logic signed [31:0] out_element_r;
  logic          out_last_r;

  logic          full;
  logic          empty;
  logic          is_err;
  logic          out_free;
  logic          s1_free;
  logic          take;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;
  logic [IW-1:0] back_slot;
  logic [SW-1:0] back_sum;

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] p);
    return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] p);
    return (p == '0) ? IW'(DEPTH - 1) : p - 1'b1;
  endfunction

  // Ring arithmetic for the current command
  assign front_inc = ring_inc(front_r);
  assign front_dec = ring_dec(front_r);
  assign back_sum  = SW'(front_r) + SW'(occ_r);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

  assign full  = occ_r == CW'(DEPTH);
  assign empty = occ_r == '0;

  // Issue control
  assign is_err    = (cmd.push && full) || (cmd.pop && empty);
  assign out_free  = !out_v_r || out_ready;
  assign s1_free   = !s1_v_r || out_free;
  assign cmd_ready = !dump_busy_r && (!is_err || s1_free);
  assign take      = cmd_valid && cmd_ready;
  assign rd_en     = dump_busy_r && s1_free;
  assign wr_en     = take && cmd.push && !full;
  assign wr_addr   = cmd.at_back ? back_slot : front_dec;

  // Deque pointers and dump sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      dump_busy_r <= 1'b0;
      rd_ptr_r    <= '0;
      rem_r       <= '0;
    end else begin
      if (take && !is_err) begin
        if (cmd.push) begin
          occ_r <= occ_r + 1'b1;
          if (!cmd.at_back) begin
            front_r <= front_dec;
          end
        end else if (cmd.pop) begin
          occ_r <= occ_r - 1'b1;
          if (!cmd.at_back) begin
            front_r <= front_inc;
          end
        end else if (cmd.dump && !empty) begin
          dump_busy_r <= 1'b1;
          rd_ptr_r    <= front_r;
          rem_r       <= occ_r;
        end
      end
      if (rd_en) begin
        rd_ptr_r <= ring_inc(rd_ptr_r);
        rem_r    <= rem_r - 1'b1;
        if (rem_r == CW'(1)) begin
          dump_busy_r <= 1'b0;
        end
      end
    end
  end

  // Element storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      mem_rd_r <= mem[rd_ptr_r];
    end
  end

  // Stage 1: result tag alongside the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rd_en || (take && is_err)) begin
      s1_v_r <= 1'b1;
    end else if (out_free) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_status_r <= ST_ELEMENT;
      s1_last_r   <= rem_r == CW'(1);
    end else if (take && is_err) begin
      s1_status_r <= cmd.push ? ST_PUSH_FULL : ST_POP_EMPTY;
      s1_last_r   <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_v_r) begin
      out_status_r  <= s1_status_r;
      out_element_r <= (s1_status_r == ST_ELEMENT) ? mem_rd_r : '0;
      out_last_r    <= s1_last_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the bounded deque engine: queue-fed driver, predictor and monitor.
module testbench;
  import bdq_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [2:0] KIND_FIRST_UNUSED = 3'd5;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VALUE_MIN = 32'sh80000000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } deque_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
  } deque_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_kind = '0;
  logic signed [31:0]  in_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_status;
  logic signed [31:0]  out_element;
  logic                out_last;

  bounded_deque_engine #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_element(out_element),
    .out_last   (out_last)
  );

  // Pending commands and expected results
  deque_cmd_t    cmd_q[$];
  deque_result_t expected_results[$];

  // Predictor state: ring storage, front slot and fill level
  logic signed [31:0] ring_store [DEPTH];
  logic [5:0]         ring_front = '0;
  logic [6:0]         ring_level = '0;

  idle_mode_t idle_mode = IDLE_NONE;
  int         gen_level = 0;   // fill level as seen by the stimulus generator
  bit         in_taken = 1'b0;
  int         error_count = 0;
  int         cmds_accepted = 0;
  int         results_checked = 0;
  int         full_errors = 0;
  int         empty_errors = 0;
  int         dump_elements = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Expected outcome of one accepted command
  function automatic void deque_execute(logic [2:0] kind, logic signed [31:0] value);
    logic [5:0] slot;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (ring_level == DEPTH) begin
          expected_results.push_back('{ST_PUSH_FULL, 32'sd0, 1'b1});
        end else begin
          if (kind == KIND_PUSH_FRONT) begin
            ring_front = ring_front - 6'd1;
            slot = ring_front;
          end else begin
            slot = ring_front + ring_level[5:0];
          end
          ring_store[slot] = value;
          ring_level = ring_level + 7'd1;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (ring_level == 0) begin
          expected_results.push_back('{ST_POP_EMPTY, 32'sd0, 1'b1});
        end else begin
          if (kind == KIND_POP_FRONT) ring_front = ring_front + 6'd1;
          ring_level = ring_level - 7'd1;
        end
      end
      KIND_DUMP: begin
        for (int i = 0; i < ring_level; i++) begin
          slot = ring_front + 6'(i);
          expected_results.push_back('{ST_ELEMENT, ring_store[slot], (i == ring_level - 1)});
        end
      end
      default: ;  // unused codes are swallowed
    endcase
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Input side: hold the transaction until taken, then maybe idle
  always @(negedge clk) begin : driver_blk
    deque_cmd_t next_cmd;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (cmd_q.size() != 0 &&
            !((idle_mode == IDLE_SENDER && chance(52)) ||
              (idle_mode == IDLE_BOTH && chance(9)))) begin
          next_cmd = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_kind  <= next_cmd.kind;
          in_value <= next_cmd.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !((idle_mode == IDLE_RECEIVER && chance(52)) ||
                     (idle_mode == IDLE_BOTH && chance(9)));
    end
    in_taken = 1'b0;
  end

  // Accept commands into the predictor and check results
  always @(posedge clk) begin : monitor_blk
    deque_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        cmds_accepted++;
        deque_execute(in_kind, in_value);
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d element %0d last %0d",
                 out_status, out_element, out_last);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            error_count++;
          end
          if (out_element !== want.element) begin
            $error("element mismatch: expected %0d, actual %0d", want.element, out_element);
            error_count++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
            error_count++;
          end
          case (want.status)
            ST_PUSH_FULL: full_errors++;
            ST_POP_EMPTY: empty_errors++;
            default:      dump_elements++;
          endcase
        end
      end
    end
  end

  // Stimulus generation; gen_level mirrors the occupancy the block will see
  task automatic send_cmd(logic [2:0] kind, logic signed [31:0] value);
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: if (gen_level < DEPTH) gen_level++;
      KIND_POP_FRONT, KIND_POP_BACK:   if (gen_level > 0) gen_level--;
      default: ;
    endcase
    cmd_q.push_back('{kind, value});
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r < (grow ? 55 : 25)) begin
      send_cmd(chance(50) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_value());
    end else if (r < 85) begin
      send_cmd(chance(50) ? KIND_POP_FRONT : KIND_POP_BACK, pick_value());
    end else if (r < 95) begin
      send_cmd(KIND_DUMP, pick_value());
    end else begin
      send_cmd(KIND_FIRST_UNUSED + 3'($urandom_range(0, 2)), pick_value());
    end
  endtask

  task automatic wait_cmds_sent();
    while (cmd_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, unused codes, extreme values, both ends
    idle_mode = IDLE_NONE;
    send_cmd(KIND_DUMP, 32'sd0);
    send_cmd(KIND_POP_FRONT, 32'sd0);
    send_cmd(KIND_POP_BACK, VALUE_MAX);
    send_cmd(KIND_FIRST_UNUSED, VALUE_MAX);
    send_cmd(KIND_FIRST_UNUSED + 3'd1, VALUE_MIN);
    send_cmd(KIND_FIRST_UNUSED + 3'd2, -32'sd1);
    send_cmd(KIND_PUSH_FRONT, VALUE_MAX);
    send_cmd(KIND_PUSH_BACK, VALUE_MIN);
    send_cmd(KIND_PUSH_FRONT, 32'sd0);
    send_cmd(KIND_PUSH_BACK, -32'sd1);
    send_cmd(KIND_PUSH_FRONT, 32'sh55555555);
    send_cmd(KIND_PUSH_BACK, 32'shaaaaaaaa);
    send_cmd(KIND_DUMP, 32'sd0);
    send_cmd(KIND_POP_FRONT, 32'sd0);
    send_cmd(KIND_POP_BACK, 32'sd0);
    send_cmd(KIND_DUMP, 32'sd0);
    repeat (4) send_cmd(chance(50) ? KIND_POP_FRONT : KIND_POP_BACK, 32'sd0);
    send_cmd(KIND_POP_BACK, 32'sd0);
    send_cmd(KIND_DUMP, 32'sd0);
    repeat (8) send_random(1'b1);
    wait_cmds_sent();

    // Fill to capacity under receiver back-pressure, overflow, full dump
    idle_mode = IDLE_RECEIVER;
    while (gen_level < DEPTH)
      send_cmd(chance(50) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_value());
    send_cmd(KIND_PUSH_FRONT, pick_value());
    send_cmd(KIND_PUSH_BACK, pick_value());
    send_cmd(KIND_DUMP, 32'sd0);
    send_cmd(KIND_POP_BACK, 32'sd0);
    send_cmd(KIND_PUSH_FRONT, pick_value());
    send_cmd(KIND_PUSH_BACK, pick_value());
    send_cmd(KIND_DUMP, 32'sd0);
    repeat (8) send_random(1'b0);
    wait_cmds_sent();

    idle_mode = IDLE_SENDER;
    repeat (8) send_random(1'b1);
    wait_cmds_sent();

    // Light idling on both sides, then a pop and a dump of what remains
    idle_mode = IDLE_BOTH;
    repeat (8) send_random(1'b0);
    send_cmd(KIND_POP_FRONT, 32'sd0);
    send_cmd(KIND_DUMP, 32'sd0);
    wait_cmds_sent();

    while (in_valid || expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d commands, %0d results: %0d dumped elements,",
             cmds_accepted, results_checked, dump_elements);
    $display("%0d full drops, %0d empty pops; idle modes: none, receiver stall, %s",
             full_errors, empty_errors, "sender gaps, both");
    $display("%0d mismatches", error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $error("timeout with %0d results still expected", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bdq_pkg.sv
sv/bdq_front.sv
sv/bdq_cmd_fifo.sv
sv/bdq_back.sv
sv/bounded_deque_engine.sv
tb/testbench.sv
